@@ design/mft_pkg.sv @@
// ----------------------------------------------------------------------------
// mft_pkg
// Shared constants, codes and types of the sorted multiset floor-take unit.
// ----------------------------------------------------------------------------
package mft_pkg;

   localparam int CAPACITY   = 1024;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_TAKEN    = 2'd1,
      ST_MISS     = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_SRCH,
      FSM_SRCH_CMP,
      FSM_INS_RD,
      FSM_INS_WR,
      FSM_TAKE_RD,
      FSM_TAKE_GET,
      FSM_DEL_RD,
      FSM_DEL_WR,
      FSM_FINISH
   } state_type;

   typedef struct packed {
      logic                  rd_en;
      logic [IDX_BITS-1:0]   rd_addr;
      logic                  wr_en;
      logic [IDX_BITS-1:0]   wr_addr;
      logic [VALUE_BITS-1:0] wr_data;
   } mem_req_type;

endpackage

@@ design/mft_req_if.sv @@
// ----------------------------------------------------------------------------
// mft_req_if
// Request channel: valid/ready handshake with op and value payload.
// ----------------------------------------------------------------------------
interface mft_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [mft_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

@@ design/mft_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mft_rsp_if
// Response channel: valid/ready handshake with status and taken value.
// ----------------------------------------------------------------------------
interface mft_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [mft_pkg::VALUE_BITS-1:0] taken_value;

   modport source (output valid, output status, output taken_value, input ready);
   modport sink   (input valid, input status, input taken_value, output ready);
endinterface

@@ design/mft_store.sv @@
// ----------------------------------------------------------------------------
// mft_store
// Sorted value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mft_store (
   input  logic                           clock,
   input  mft_pkg::mem_req_type           mem_req,
   output logic [mft_pkg::VALUE_BITS-1:0] rd_data
);

   logic [mft_pkg::VALUE_BITS-1:0] mem [mft_pkg::CAPACITY];
   logic [mft_pkg::VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/multiset_floor_take_unit.sv @@
// ----------------------------------------------------------------------------
// multiset_floor_take_unit
// Bounded sorted multiset: insert a value, or take the largest value <= limit.
// ----------------------------------------------------------------------------
// Sequence: accept, then a read and a compare per binary search step (up to
//   ceil(log2(n+1)) steps for n entries), a read of the taken entry on a take,
//   a read and a write per shifted entry, then finish; a full-store insert goes
//   straight to finish. One request at a time; the entry shift bounds throughput.
// Reset: synchronous, clears entry count and control; store contents are
//   left as they are and only written positions are ever read.
module multiset_floor_take_unit (
   input  logic          clock,
   input  logic          reset,
   mft_req_if.sink       req_ch,
   mft_rsp_if.source     rsp_ch
);

   localparam int IB = mft_pkg::IDX_BITS;
   localparam int CB = mft_pkg::CNT_BITS;
   localparam int VB = mft_pkg::VALUE_BITS;

   mft_pkg::state_type   state_ff, state_in;
   logic                 op_ff, op_in;
   logic [VB-1:0]        val_ff, val_in;
   logic [CB-1:0]        lo_ff, lo_in;
   logic [CB-1:0]        hi_ff, hi_in;
   logic [IB-1:0]        mid_ff, mid_in;
   logic [CB-1:0]        cur_ff, cur_in;
   logic [CB-1:0]        count_ff, count_in;
   mft_pkg::status_type  res_status_ff, res_status_in;
   logic [VB-1:0]        res_taken_ff, res_taken_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mft_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [VB-1:0]        rsp_taken_ff, rsp_taken_in;

   mft_pkg::mem_req_type mem_req;
   logic [VB-1:0]        rd_data;

   logic                 req_fire;
   logic                 is_full;
   logic                 slot_free;
   logic [CB-1:0]        mid_full;
   logic [CB-1:0]        cur_dec;
   logic [CB-1:0]        lo_dec;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign is_full   = (count_ff == CB'(mft_pkg::CAPACITY));
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign mid_full  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cur_dec   = cur_ff - CB'(1);
   assign lo_dec    = lo_ff - CB'(1);

   assign req_ch.ready       = (state_ff == mft_pkg::FSM_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.taken_value = rsp_taken_ff;

   mft_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mft_pkg::FSM_IDLE: begin
            if (req_fire) begin
               if (req_ch.op == mft_pkg::OP_INSERT && is_full) begin
                  state_in = mft_pkg::FSM_FINISH;
               end else begin
                  state_in = mft_pkg::FSM_SRCH;
               end
            end
         end
         mft_pkg::FSM_SRCH: begin
            if (lo_ff < hi_ff) begin
               state_in = mft_pkg::FSM_SRCH_CMP;
            end else if (op_ff == mft_pkg::OP_INSERT) begin
               state_in = mft_pkg::FSM_INS_RD;
            end else if (lo_ff == '0) begin
               state_in = mft_pkg::FSM_FINISH;
            end else begin
               state_in = mft_pkg::FSM_TAKE_RD;
            end
         end
         mft_pkg::FSM_SRCH_CMP: state_in = mft_pkg::FSM_SRCH;
         mft_pkg::FSM_INS_RD: begin
            state_in = (cur_ff > lo_ff) ? mft_pkg::FSM_INS_WR : mft_pkg::FSM_FINISH;
         end
         mft_pkg::FSM_INS_WR:   state_in = mft_pkg::FSM_INS_RD;
         mft_pkg::FSM_TAKE_RD:  state_in = mft_pkg::FSM_TAKE_GET;
         mft_pkg::FSM_TAKE_GET: state_in = mft_pkg::FSM_DEL_RD;
         mft_pkg::FSM_DEL_RD: begin
            state_in = (cur_ff < count_ff) ? mft_pkg::FSM_DEL_WR : mft_pkg::FSM_FINISH;
         end
         mft_pkg::FSM_DEL_WR:   state_in = mft_pkg::FSM_DEL_RD;
         mft_pkg::FSM_FINISH: begin
            if (slot_free) begin
               state_in = mft_pkg::FSM_IDLE;
            end
         end
         default: state_in = mft_pkg::FSM_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_taken_in  = res_taken_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_taken_in  = rsp_taken_ff;
      mem_req       = '0;
      unique case (state_ff)
         mft_pkg::FSM_IDLE: begin
            if (req_fire) begin
               op_in         = req_ch.op;
               val_in        = req_ch.value;
               lo_in         = '0;
               hi_in         = count_ff;
               res_taken_in  = '0;
               res_status_in = mft_pkg::ST_FULL;
            end
         end
         mft_pkg::FSM_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in          = mid_full[IB-1:0];
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid_full[IB-1:0];
            end else if (op_ff == mft_pkg::OP_INSERT) begin
               cur_in = count_ff;
            end else if (lo_ff == '0) begin
               res_status_in = mft_pkg::ST_MISS;
            end
         end
         mft_pkg::FSM_SRCH_CMP: begin
            if (rd_data <= val_ff) begin
               lo_in = CB'(mid_ff) + CB'(1);
            end else begin
               hi_in = CB'(mid_ff);
            end
         end
         mft_pkg::FSM_INS_RD: begin
            if (cur_ff > lo_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cur_dec[IB-1:0];
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = lo_ff[IB-1:0];
               mem_req.wr_data = val_ff;
               count_in        = count_ff + CB'(1);
               res_status_in   = mft_pkg::ST_INSERTED;
            end
         end
         mft_pkg::FSM_INS_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff[IB-1:0];
            mem_req.wr_data = rd_data;
            cur_in          = cur_dec;
         end
         mft_pkg::FSM_TAKE_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = lo_dec[IB-1:0];
         end
         mft_pkg::FSM_TAKE_GET: begin
            res_taken_in = rd_data;
            cur_in       = lo_ff;
         end
         mft_pkg::FSM_DEL_RD: begin
            if (cur_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cur_ff[IB-1:0];
            end else begin
               count_in      = count_ff - CB'(1);
               res_status_in = mft_pkg::ST_TAKEN;
            end
         end
         mft_pkg::FSM_DEL_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_dec[IB-1:0];
            mem_req.wr_data = rd_data;
            cur_in          = cur_ff + CB'(1);
         end
         mft_pkg::FSM_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_taken_in  = res_taken_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mft_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_taken_ff  <= res_taken_in;
      rsp_status_ff <= rsp_status_in;
      rsp_taken_ff  <= rsp_taken_in;
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(mft_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.op == mft_pkg::OP_INSERT && is_full)
      |=> (state_ff == mft_pkg::FSM_FINISH && res_status_ff == mft_pkg::ST_FULL
           && $stable(count_ff)))
      else $error("full-store insert not dropped");

   a_taken_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mft_pkg::FSM_FINISH && res_status_ff != mft_pkg::ST_TAKEN)
      |-> (res_taken_ff == '0))
      else $error("taken value nonzero without a take");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == mft_pkg::FSM_INS_RD || state_ff == mft_pkg::FSM_DEL_RD)
      |=> $stable(count_ff))
      else $error("entry count changed outside commit");

endmodule
